// ===== design/spq_pkg.sv =====
// shared types, codes and defaults for the sorted priority queue
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              kind;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic signed [31:0] head_value;
    logic               head_valid;
    logic [4:0]         count;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_PUT  = 4'b0100,
    S_POP  = 4'b1000
  } state_t;

endpackage

// ===== design/spq_ram.sv =====
// generic simple dual port ram with registered read
module spq_ram import spq_pkg::*; #(
  parameter int WIDTH = VAL_W,
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sorted_priority_queue.sv =====
// sorted priority queue: top level with sequencer, shared comparator and entry ram
// sequence: refused items, inserts at or above the head and removes that empty the queue
//   finish straight from S_IDLE; any other remove passes through S_POP (one ram read for the
//   new head); an insert below the head stays in S_INS while the entry read is larger than
//   the value, walking entries up one slot with one ram read and one compare per cycle, and
//   ends in S_INS or S_PUT, which gives out_valid
// throughput: a new transaction is taken in the cycle its predecessor's result is strobed;
//   results are never stalled, the receiver cannot hold them off
// reset: rst_n is synchronous active low, empties the queue; ram contents are not cleared
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // entries are held ascending: slot 0 smallest, slot count-1 the head
  state_t             state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] head_r, head_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic signed [31:0] rem_r, rem_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  // ram ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [31:0]        wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  // the one comparator, shared between the head check and the walk
  logic signed [31:0] cmp_a;
  logic signed [31:0] cmp_b;
  logic               cmp_gt;

  logic               accept;
  logic               finish;
  status_t            status_nxt;
  logic [CW+4:0]      cnt_ext;
  logic [CW-1:0]      cnt_m1;
  logic [CW-1:0]      cnt_m2;

  spq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept = start && (state_r == S_IDLE);
  assign cmp_a  = (state_r == S_IDLE) ? head_r : $signed(rd_data);
  assign cmp_b  = (state_r == S_IDLE) ? in_data.value : val_r;
  assign cmp_gt = cmp_a > cmp_b;
  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    val_nxt    = val_r;
    rem_nxt    = rem_r;
    finish     = 1'b0;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = idx_r + AW'(1);
    wr_data    = val_r;
    rd_en      = 1'b0;
    rd_addr    = idx_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          val_nxt = in_data.value;
          rem_nxt = '0;
          if (in_data.kind == KIND_INSERT) begin
            if (cnt_r == CW'(DEPTH)) begin
              // full: refuse, state untouched
              finish     = 1'b1;
              status_nxt = ST_FULL;
            end else if (cnt_r == '0 || !cmp_gt) begin
              // new head goes straight on top
              wr_en    = 1'b1;
              wr_addr  = cnt_r[AW-1:0];
              wr_data  = in_data.value;
              head_nxt = in_data.value;
              cnt_nxt  = cnt_r + CW'(1);
              finish   = 1'b1;
            end else begin
              // walk down from the head moving larger entries up
              rd_en     = 1'b1;
              rd_addr   = cnt_m1[AW-1:0];
              idx_nxt   = cnt_m1[AW-1:0];
              cnt_nxt   = cnt_r + CW'(1);
              state_nxt = S_INS;
            end
          end else begin
            if (cnt_r == '0) begin
              finish     = 1'b1;
              status_nxt = ST_EMPTY;
            end else begin
              rem_nxt = head_r;
              cnt_nxt = cnt_m1;
              if (cnt_r == CW'(1)) begin
                head_nxt = '0;
                finish   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = cnt_m2[AW-1:0];
                state_nxt = S_POP;
              end
            end
          end
        end
      end
      S_INS: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - AW'(1);
            idx_nxt = idx_r - AW'(1);
          end
        end else begin
          wr_data   = val_r;
          finish    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PUT: begin
        // value is the new minimum
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        head_nxt  = $signed(rd_data);
        finish    = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    cnt_ext               = {5'd0, cnt_nxt};
    out_nxt.status        = status_nxt;
    out_nxt.removed_value = rem_nxt;
    out_nxt.head_valid    = (cnt_nxt != '0);
    out_nxt.head_value    = (cnt_nxt != '0) ? head_nxt : '0;
    out_nxt.count         = cnt_ext[4:0];
    out_valid_nxt         = finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    if (finish) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only ever appears with the sequencer back at rest
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while sequencer busy");

  // every accepted transaction either keeps the block busy or finishes at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted transaction lost");

  // fill level never passes capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count beyond capacity");

  // head flag agrees with the stored count
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.head_valid == (cnt_r != '0)))
    else $error("head valid flag disagrees with count");

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the sorted priority queue
module tb;
  import spq_pkg::*;

  localparam int QDEPTH = DEPTH_DEFAULT;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 400;
  // the last stretch of random transactions runs with no idling at all
  localparam int CALM_FROM = 320;
  // an insert below the head walks at most QDEPTH-1 entries, so this covers any tail
  localparam int DRAIN_CYCLES = QDEPTH + 8;

  // one row of the directed script; want is only meaningful when typed is set
  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value;
    logic               typed;
    out_t               want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // sorted copy of the stored values, largest first
  logic signed [31:0] ranked[$];
  // results still owed by the block, oldest first
  out_t pending[$];
  int   mismatches = 0;
  // chance in percent that a transaction is preceded by an idle burst
  int   gap_pct = 0;

  // directed script: empty and full refusals, extremes, equal values, mixed bit patterns
  script_row_t script [24] = '{
    '{KIND_REMOVE, 32'sd0,          1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 1'b0, 5'd0}},
    '{KIND_INSERT, VAL_MIN,         1'b1, '{ST_DONE, 32'sd0, VAL_MIN, 1'b1, 5'd1}},
    '{KIND_INSERT, VAL_MAX,         1'b1, '{ST_DONE, 32'sd0, VAL_MAX, 1'b1, 5'd2}},
    '{KIND_REMOVE, 32'shffff_ffff,  1'b1, '{ST_DONE, VAL_MAX, VAL_MIN, 1'b1, 5'd1}},
    '{KIND_REMOVE, 32'sh5555_5555,  1'b1, '{ST_DONE, VAL_MIN, 32'sd0, 1'b0, 5'd0}},
    '{KIND_REMOVE, 32'shaaaa_aaaa,  1'b1, '{ST_EMPTY, 32'sd0, 32'sd0, 1'b0, 5'd0}},
    '{KIND_INSERT, 32'sd0,          1'b0, '0},
    '{KIND_INSERT, -32'sd1,         1'b0, '0},
    '{KIND_INSERT, 32'sd1,          1'b0, '0},
    '{KIND_INSERT, 32'sd0,          1'b0, '0},
    '{KIND_INSERT, VAL_MAX,         1'b0, '0},
    '{KIND_INSERT, VAL_MIN,         1'b0, '0},
    '{KIND_INSERT, 32'sd5,          1'b0, '0},
    '{KIND_INSERT, 32'sd5,          1'b0, '0},
    '{KIND_INSERT, -32'sd5,         1'b0, '0},
    '{KIND_INSERT, 32'sd100,        1'b0, '0},
    '{KIND_INSERT, -32'sd100,       1'b0, '0},
    '{KIND_INSERT, 32'sh5555_5555,  1'b0, '0},
    '{KIND_INSERT, 32'shaaaa_aaaa,  1'b0, '0},
    '{KIND_INSERT, 32'sd7,          1'b0, '0},
    '{KIND_INSERT, 32'sd1,          1'b0, '0},
    '{KIND_INSERT, -32'sd1,         1'b0, '0},
    // sixteen stored, so this one bounces off with the head unchanged
    '{KIND_INSERT, 32'sd42,         1'b1, '{ST_FULL, 32'sd0, VAL_MAX, 1'b1, 5'd16}},
    '{KIND_REMOVE, 32'sd0,          1'b0, '0}
  };

  sorted_priority_queue #(.DEPTH(QDEPTH)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // apply one transaction to the sorted copy and return what the block should report
  function automatic out_t queue_apply(input in_t item);
    out_t res;
    int   slot;
    res = '0;
    res.status = ST_DONE;
    if (item.kind == KIND_INSERT) begin
      if (ranked.size() >= QDEPTH) begin
        res.status = ST_FULL;
      end else begin
        // new value lands after every stored value that is not smaller
        slot = 0;
        while (slot < ranked.size() && ranked[slot] >= item.value) slot++;
        ranked.insert(slot, item.value);
      end
    end else begin
      if (ranked.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = ranked.pop_front();
      end
    end
    res.head_valid = (ranked.size() > 0);
    res.head_value = res.head_valid ? ranked[0] : 32'sd0;
    res.count      = CNT_OUT_W'(ranked.size());
    return res;
  endfunction

  task automatic note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  // offer one transaction, optionally after an idle burst, and wait until it is taken;
  // start is left high so a following transaction can go back to back
  task automatic issue(input in_t item, input logic typed, input out_t typed_want);
    out_t predicted;
    int   gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 12);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    // taken at this edge: the predictor always advances, even when the row is typed
    predicted = queue_apply(item);
    pending.push_back(typed ? typed_want : predicted);
  endtask

  // values biased towards extremes and a narrow band, so equal keys are frequent
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 32'sd8;
      default: return $signed($urandom());
    endcase
  endfunction

  // results are strobed for one cycle and cannot be held off, so check every strobe
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        note_fault($sformatf("result with no transaction pending (count %0d)",
                             out_data.count));
      end else begin
        want = pending.pop_front();
        if (out_data.status !== want.status)
          note_fault($sformatf("status expected %0d got %0d", want.status, out_data.status));
        if (out_data.removed_value !== want.removed_value)
          note_fault($sformatf("removed_value expected %0d got %0d",
                               want.removed_value, out_data.removed_value));
        if (out_data.head_value !== want.head_value)
          note_fault($sformatf("head_value expected %0d got %0d",
                               want.head_value, out_data.head_value));
        if (out_data.head_valid !== want.head_valid)
          note_fault($sformatf("head_valid expected %0d got %0d",
                               want.head_valid, out_data.head_valid));
        if (out_data.count !== want.count)
          note_fault($sformatf("count expected %0d got %0d", want.count, out_data.count));
      end
    end
  end

  initial begin : stimulus
    int   insert_pct;
    in_t  item;
    kind_t k;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed script, with light idling so gaps land between the early transactions
    gap_pct = 30;
    foreach (script[i]) begin
      item.kind  = script[i].kind;
      item.value = script[i].value;
      issue(item, script[i].typed, script[i].want);
    end

    // random part in blocks: each block leans towards filling or draining, so the
    // queue swings between empty and full and inserts land at every depth
    insert_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          2:       insert_pct = 75;
          default: insert_pct = 95;
        endcase
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 25;
          default: gap_pct = 50;
        endcase
      end
      if (n >= CALM_FROM) gap_pct = 0;
      k = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
      item.kind = k;
      // the value rides along on a remove too, where it must be ignored
      item.value = pick_value();
      issue(item, 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    // let any stray strobe show itself before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin : watchdog
    #400000;
    $display("[sorted_priority_queue] ERROR");
    $finish;
  end

endmodule
